// ----- rtl/sfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_pkg: shared types and constants of the sensor frame encoder
// Queue item layout, back-end status, register indexes and the CRC-32 byte
// update.
// ----------------------------------------------------------------------------
package sfe_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
	localparam logic [15:0] LENGTH_RESET = 16'd236;

	// configuration register indexes
	localparam logic [1:0] REG_MAGIC   = 2'd0;
	localparam logic [1:0] REG_VERSION = 2'd1;
	localparam logic [1:0] REG_LENGTH  = 2'd2;

	typedef struct packed {
		logic [31:0] word;
		logic        last;   // final payload word of the frame
		logic        start;  // first payload word: header goes first
	} item_t;

	typedef struct packed {
		logic dispatch;  // back end takes a new item from the queue head
		logic cnt_zero;  // byte count is at its frame-start value
	} back_stat_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc,
			input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int b = 0; b < 8; b++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

// ----- rtl/sensor_frame_encoder_crc32.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_encoder_crc32: telemetry framer with CRC-32 trailer
// Turns 32-bit payload words into a big-endian byte stream with header and
// reflected CRC-32 trailer.
// ----------------------------------------------------------------------------
// Usage
//   in channel  : in_valid/in_ready, payload_word, ends_frame. One item is one
//                 payload word; ends_frame marks the last word of a frame.
//   out channel : out_valid/out_ready, out_byte, frame_done, status. One item
//                 per byte. The first word of a frame is preceded by 8 header
//                 bytes (magic, version, frame length, big-endian). The last
//                 word is followed by 4 CRC bytes, or by one item with
//                 status=1, out_byte=0 when the byte count is off.
//   cfg channel : cfg_valid/cfg_ready (always ready), cfg_index, cfg_data.
//                 Index 0 magic, 1 version, 2 frame length; index 3 ignored.
//                 Write only while the encoder is idle.
// Timing
//   out_valid for the first byte of an accepted item rises once the item has
//   passed through the queue and the output register. Each word gives 4 output
//   bytes, 12 for the first word of a frame, plus 4 (CRC) or 1 (error) at
//   its end. The byte-wide output register paces the output; a 2-entry queue
//   lets the input keep accepting while the byte sequencer works.
// Reset clears the frame state: the next word opens a new frame. A stalled
// receiver holds the current byte; the queue then fills and in_ready drops.
// ----------------------------------------------------------------------------
module sensor_frame_encoder_crc32 #(
	parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] payload_word,
	input  logic        ends_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_done,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration registers
	logic [31:0] magic_q;
	logic [15:0] version_q;
	logic [15:0] length_q;

	// front to queue
	logic           push;
	sfe_pkg::item_t push_item;
	logic           q_full;

	// queue to back
	logic           head_valid;
	sfe_pkg::item_t head_item;
	logic           pop;

	sfe_pkg::back_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= 32'd0;
			version_q <= 16'd0;
			length_q  <= sfe_pkg::LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfe_pkg::REG_MAGIC:   magic_q   <= cfg_data;
				sfe_pkg::REG_VERSION: version_q <= cfg_data[15:0];
				sfe_pkg::REG_LENGTH:  length_q  <= cfg_data[15:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// front: accept and mark frame starts
	sfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_word (payload_word),
		.ends_frame   (ends_frame),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	sfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.full       (q_full)
	);

	// back: byte sequencing, CRC and length check
	sfe_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_magic    (magic_q),
		.format_version (version_q),
		.frame_length   (length_q),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.frame_done     (frame_done),
		.status         (status),
		.stat           (stat)
	);

	// an error item always closes the frame with a zero byte
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> frame_done && (out_byte == 8'd0))
		else $error("error item without frame_done or with nonzero byte");

	// front and back agree on frame boundaries
	a_frame_sync: assert property (@(posedge clk) disable iff (!arst_n)
		stat.dispatch |-> (head_item.start == stat.cnt_zero))
		else $error("frame start marking disagrees with byte count");

	// a pop only ever comes from a non-empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

endmodule

// ----- rtl/sfe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_front: input stage
// Accepts payload items and marks the ones that open a new frame.
// ----------------------------------------------------------------------------
module sfe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          payload_word,
	input  logic                 ends_frame,
	input  logic                 q_full,
	output logic                 push,
	output sfe_pkg::item_t       push_item
);

	logic inside_q;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_item.word  = payload_word;
		push_item.last  = ends_frame;
		push_item.start = !inside_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (push) begin
			inside_q <= !ends_frame;
		end
	end

endmodule

// ----- rtl/sfe_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_queue: item queue between front and back
// Small register FIFO; head is shown combinationally.
// ----------------------------------------------------------------------------
module sfe_queue #(
	parameter int DEPTH = sfe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfe_pkg::item_t push_item,
	input  logic           pop,
	output logic           head_valid,
	output sfe_pkg::item_t head_item,
	output logic           full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sfe_pkg::item_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == FULL_CNT);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sfe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_back: byte sequencer
// Emits header, payload, CRC or error bytes into the output register and
// keeps the running CRC and byte count.
// ----------------------------------------------------------------------------
module sfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         frame_magic,
	input  logic [15:0]         format_version,
	input  logic [15:0]         frame_length,
	input  logic                head_valid,
	input  sfe_pkg::item_t      head_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                frame_done,
	output logic                status,
	output sfe_pkg::back_stat_t stat
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_HDR  = 3'd1;
	localparam logic [2:0] PH_WORD = 3'd2;
	localparam logic [2:0] PH_CRC  = 3'd3;
	localparam logic [2:0] PH_ERR  = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic [31:0] crc_q;
	logic [15:0] cnt_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_done_q;
	logic        out_status_q;

	logic        go, emit, fire, feed, pop_c, frame_end, match;
	logic [7:0]  byte_c;
	logic        done_c, st_c;
	logic [63:0] hdr, hdr_sh;
	logic [31:0] word_sh, crc_sh;

	assign go   = !out_valid_q || out_ready;
	assign fire = go && emit;
	assign pop  = go && pop_c;

	assign hdr     = {frame_magic, format_version, frame_length};
	assign hdr_sh  = hdr << {idx_q, 3'b000};
	assign word_sh = head_item.word << {idx_q[1:0], 3'b000};
	assign crc_sh  = (~crc_q) << {idx_q[1:0], 3'b000};
	// count before the last payload byte, plus that byte and the CRC
	assign match   = ({1'b0, cnt_q} + 17'd5) == {1'b0, frame_length};

	always_comb begin
		emit      = 1'b0;
		feed      = 1'b0;
		pop_c     = 1'b0;
		frame_end = 1'b0;
		byte_c    = 8'd0;
		done_c    = 1'b0;
		st_c      = 1'b0;
		phase_d   = phase_q;
		idx_d     = idx_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (head_valid) begin
					emit  = 1'b1;
					feed  = 1'b1;
					idx_d = 3'd1;
					if (head_item.start) begin
						byte_c  = hdr[63:56];
						phase_d = PH_HDR;
					end else begin
						byte_c  = head_item.word[31:24];
						phase_d = PH_WORD;
					end
				end
			end
			PH_HDR: begin
				emit   = 1'b1;
				feed   = 1'b1;
				byte_c = hdr_sh[63:56];
				if (idx_q == 3'd7) begin
					idx_d   = 3'd0;
					phase_d = PH_WORD;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_WORD: begin
				emit   = 1'b1;
				feed   = 1'b1;
				byte_c = word_sh[31:24];
				if (idx_q[1:0] == 2'd3) begin
					pop_c = 1'b1;
					idx_d = 3'd0;
					if (!head_item.last) begin
						phase_d = PH_IDLE;
					end else if (match) begin
						phase_d = PH_CRC;
					end else begin
						phase_d = PH_ERR;
					end
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_CRC: begin
				emit   = 1'b1;
				byte_c = crc_sh[31:24];
				if (idx_q[1:0] == 2'd3) begin
					done_c    = 1'b1;
					frame_end = 1'b1;
					idx_d     = 3'd0;
					phase_d   = PH_IDLE;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_ERR: begin
				emit      = 1'b1;
				done_c    = 1'b1;
				st_c      = 1'b1;
				frame_end = 1'b1;
				idx_d     = 3'd0;
				phase_d   = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
				idx_d   = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			idx_q       <= 3'd0;
			crc_q       <= sfe_pkg::CRC_INIT;
			cnt_q       <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= phase_d;
				idx_q       <= idx_d;
				out_valid_q <= 1'b1;
				if (frame_end) begin
					crc_q <= sfe_pkg::CRC_INIT;
					cnt_q <= 16'd0;
				end else if (feed) begin
					crc_q <= sfe_pkg::crc_byte(crc_q, byte_c);
					if (cnt_q != 16'hFFFF) begin
						cnt_q <= cnt_q + 16'd1;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q   <= byte_c;
			out_done_q   <= done_c;
			out_status_q <= st_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign frame_done = out_done_q;
	assign status     = out_status_q;

	assign stat.dispatch = fire && (phase_q == PH_IDLE);
	assign stat.cnt_zero = (cnt_q == 16'd0);

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sensor frame encoder with CRC-32 trailer
// Drives payload words and register writes into the encoder. An in-bench
// frame builder predicts every byte, including header, CRC trailer and length
// error items, and a checker compares each output item against it.
// ----------------------------------------------------------------------------
module tb_top;

	// index past the register list: the encoder must ignore writes to it
	localparam logic [1:0]  REG_SPARE   = 2'd3;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
	localparam int          HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int          TAIL_CYCLES = 16;   // settle time at the very end
	localparam int          IDLE_GAP    = 8;    // quiet cycles before a reg write

	// one output item: byte, end-of-frame mark, length error flag
	typedef struct packed {
		logic [7:0] data;
		logic       done;
		logic       err;
	} frame_byte_t;

	// DUT ports, the bench-driven ones known from time zero
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [31:0] payload_word = '0;
	logic        ends_frame   = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_done;
	logic        status;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index    = '0;
	logic [31:0] cfg_data     = '0;

	// frame builder state, mirrors the encoder's registers and frame progress
	logic [31:0] cur_magic   = '0;
	logic [15:0] cur_version = '0;
	logic [15:0] cur_length  = sfe_pkg::LENGTH_RESET;
	logic        open_frame  = 1'b0;
	logic [31:0] crc_acc     = sfe_pkg::CRC_INIT;
	logic [15:0] byte_count  = '0;

	frame_byte_t frame_bytes_due[$];  // bytes predicted but not yet seen
	frame_byte_t want;

	// traffic shaping
	int          src_idle_pct  = 20;
	int          sink_idle_pct = 80;
	logic        hold_req      = 1'b0;
	int          hold_left     = 0;

	// bookkeeping
	int          mismatches    = 0;
	int          words_sent    = 0;
	int          frames_sent   = 0;
	int          bytes_checked = 0;

	sensor_frame_encoder_crc32 u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.payload_word(payload_word),
		.ends_frame  (ends_frame),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.frame_done  (frame_done),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Frame builder
	// ------------------------------------------------------------------------

	// reflected CRC-32, bit-serial, LSB of the byte first
	function automatic logic [31:0] crc32_step(input logic [31:0] acc,
			input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r  = r >> 1;
			if (fb) begin
				r = r ^ sfe_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	// a sent byte feeds the CRC and the (saturating) byte count
	task automatic put_byte(input logic [7:0] b);
		crc_acc = crc32_step(crc_acc, b);
		if (byte_count != COUNT_MAX) begin
			byte_count++;
		end
		frame_bytes_due.push_back('{b, 1'b0, 1'b0});
	endtask

	// all bytes that one accepted payload word causes
	task automatic encode_word(input logic [31:0] w, input logic is_last);
		logic [31:0] crc_out;
		if (!open_frame) begin
			// header: magic, version, length, all big-endian
			for (int i = 3; i >= 0; i--) begin
				put_byte(cur_magic[8*i +: 8]);
			end
			put_byte(cur_version[15:8]);
			put_byte(cur_version[7:0]);
			put_byte(cur_length[15:8]);
			put_byte(cur_length[7:0]);
			open_frame = 1'b1;
		end
		for (int i = 3; i >= 0; i--) begin
			put_byte(w[8*i +: 8]);
		end
		if (is_last) begin
			// wide compare: a saturated count must never wrap into a match
			if ({1'b0, byte_count} + 17'd4 == {1'b0, cur_length}) begin
				crc_out = ~crc_acc;
				for (int i = 3; i >= 0; i--) begin
					frame_bytes_due.push_back('{crc_out[8*i +: 8], i == 0, 1'b0});
				end
			end else begin
				frame_bytes_due.push_back('{8'h00, 1'b1, 1'b1});
			end
			open_frame = 1'b0;
			crc_acc    = sfe_pkg::CRC_INIT;
			byte_count = '0;
			frames_sent++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offer one payload item; valid stays up across back-to-back items so it
	// is only written once per step. Prediction happens at the accepting edge.
	task automatic send_item(input logic [31:0] w, input logic is_last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		payload_word <= w;
		ends_frame   <= is_last;
		do @(posedge clk); while (!in_ready);
		encode_word(w, is_last);
		words_sent++;
	endtask

	task automatic send_frame(input int n_words);
		for (int i = 0; i < n_words; i++) begin
			send_item($urandom(), i == n_words - 1);
		end
	endtask

	// drop valid, wait for every predicted byte, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (frame_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	// register write; only called while the encoder is idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sfe_pkg::REG_MAGIC: begin
				cur_magic = data;
			end
			sfe_pkg::REG_VERSION: begin
				cur_version = data[15:0];
			end
			sfe_pkg::REG_LENGTH: begin
				cur_length = data[15:0];
			end
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly short frames, some longer, a few arbitrary lengths
	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			return 16'(12 + 4 * $urandom_range(1, 8));
		end else if (r < 95) begin
			return 16'(12 + 4 * $urandom_range(9, 40));
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic reconfigure();
		wait_idle();
		write_reg(sfe_pkg::REG_MAGIC, $urandom());
		write_reg(sfe_pkg::REG_VERSION, $urandom());
		// upper data bits must be ignored by the 16-bit registers
		write_reg(sfe_pkg::REG_LENGTH, {16'($urandom()), pick_length()});
		if ($urandom_range(0, 7) == 0) begin
			write_reg(REG_SPARE, $urandom());
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Checker: every accepted output item against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			bytes_checked++;
			if (frame_bytes_due.size() == 0) begin
				mismatches++;
				$display("%0t: expected nothing, got byte=%h done=%b status=%b",
					$time, out_byte, frame_done, status);
			end else begin
				want = frame_bytes_due.pop_front();
				if (out_byte !== want.data || frame_done !== want.done ||
						status !== want.err) begin
					mismatches++;
					$display("%0t: exp byte/done/st %h/%b/%b got %h/%b/%b",
						$time, want.data, want.done, want.err,
						out_byte, frame_done, status);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// registers at reset values: zero magic and version, length 236, so a one-word
	// frame ends in a length error
	task automatic test_reset_defaults();
		send_item(32'h0123_4567, 1'b1);
	endtask

	// all-ones and all-zeros magic, version and payload, both with a valid CRC
	task automatic test_register_extremes();
		wait_idle();
		write_reg(sfe_pkg::REG_MAGIC, 32'hFFFF_FFFF);
		write_reg(sfe_pkg::REG_VERSION, 32'hFFFF_FFFF);
		write_reg(sfe_pkg::REG_LENGTH, 32'd16);
		send_item(32'hFFFF_FFFF, 1'b1);
		wait_idle();
		write_reg(sfe_pkg::REG_MAGIC, 32'h0);
		write_reg(sfe_pkg::REG_VERSION, 32'h0);
		write_reg(sfe_pkg::REG_LENGTH, 32'd20);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b1);
	endtask

	// a write past the register list changes nothing
	task automatic test_spare_index();
		wait_idle();
		write_reg(sfe_pkg::REG_MAGIC, 32'hA5C3_0F81);
		write_reg(sfe_pkg::REG_LENGTH, 32'd16);
		write_reg(REG_SPARE, 32'd20);
		send_item(32'h8000_0001, 1'b1);
	endtask

	// lengths that can never match, plus the largest length
	task automatic test_unmatched_lengths();
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'd0);
		send_item(32'h7FFF_FFFE, 1'b1);
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'd3);
		send_item(32'h5555_AAAA, 1'b1);
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'd12);
		send_item(32'hAAAA_5555, 1'b1);
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'hFFFF_FFFF);
		send_item(32'hDEAD_BEEF, 1'b1);
	endtask

	// registers change while a frame is open: header keeps the old values,
	// the end check uses the new length
	task automatic test_midframe_change();
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'd20);
		send_item(32'h1122_3344, 1'b0);
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'd24);
		write_reg(sfe_pkg::REG_MAGIC, 32'h0BAD_F00D);
		send_item(32'h5566_7788, 1'b0);
		send_item(32'h99AA_BBCC, 1'b1);
	endtask

	// single-word frames with no gaps on either side
	task automatic test_back_to_back();
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'd16);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		for (int i = 0; i < 4; i++) begin
			send_item($urandom(), 1'b1);
		end
		src_idle_pct  = 20;
		sink_idle_pct = 80;
	endtask

	// receiver holds off while the sender keeps offering: queue fills,
	// in_ready must drop and no byte may be lost
	task automatic test_backpressure();
		wait_idle();
		write_reg(sfe_pkg::REG_LENGTH, 32'd60);
		src_idle_pct = 0;
		hold_req     = 1'b1;
		@(posedge clk);
		send_frame(12);
		src_idle_pct = 20;
	endtask

	// random frames, mostly well formed, under one idle pattern
	task automatic test_random_traffic(input int src_pct, input int sink_pct,
			input int n_items);
		int   left;
		int   n_words;
		int   fit_words;
		logic fits;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		reconfigure();
		left = n_items;
		while (left > 0) begin
			if ($urandom_range(0, 3) == 0) begin
				reconfigure();
			end
			fit_words = (int'(cur_length) - 12) / 4;
			fits = (cur_length >= 16) && (cur_length[1:0] == 2'b00) &&
				(fit_words <= 64);
			if (fits && $urandom_range(0, 99) < 80) begin
				n_words = fit_words;
			end else begin
				// broken frame: wrong word count
				n_words = $urandom_range(1, 10);
				if (fits && n_words == fit_words) begin
					n_words++;
				end
			end
			send_frame(n_words);
			left -= n_words;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_spare_index();
		test_unmatched_lengths();
		test_midframe_change();
		test_back_to_back();
		test_backpressure();
		test_random_traffic(20, 80, 110);
		test_random_traffic(80, 20, 110);
		test_random_traffic(0, 0, 110);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d payload words in %0d frames, %0d output bytes checked,",
			words_sent, frames_sent, bytes_checked);
		$display("with register extremes, length errors and a long receiver stall.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog: ends a run that does not complete
	initial begin
		#4000000;
		$display("Timeout: run did not complete, %0d bytes still expected",
			frame_bytes_due.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sfe_pkg.sv
rtl/sfe_front.sv
rtl/sfe_queue.sv
rtl/sfe_back.sv
rtl/sensor_frame_encoder_crc32.sv
sim/tb_top.sv
